// ===== design/srt_pkg.sv =====
// Shared types and constants of the sorted region table.
// Holds request and result layouts, command and status codes and cell control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

    localparam int ADDR_W   = 48;
    localparam int FLAGS_W  = 8;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 7;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 48'h8000_0000_0000;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic               cmd;
        logic [ADDR_W-1:0]  start_addr;
        logic [ADDR_W-1:0]  end_addr;
        logic [FLAGS_W-1:0] region_flags_in;
        logic [ADDR_W-1:0]  query_addr;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   hit_start;
        logic [ADDR_W-1:0]   hit_end;
        logic [FLAGS_W-1:0]  hit_flags;
        logic [ENTRY_W-1:0]  entry_count;
    } t_rsp;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp;
        logic find;
        logic ins;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/sorted_region_table.sv =====
// Top level of the sorted region table: request intake, sequencer, cell row and result register.
// Depends on srt_pkg, srt_cell and srt_or_tree.
//
// Usage: requests arrive on i_in / i_in_valid and are taken when o_in_stall is low.
// Each request gives exactly one result on o_out / o_out_valid, held until i_out_stall is low.
// An insert stores a page aligned region in sorted order unless the range is bad, it
// overlaps a stored region or the table is full; a find returns the region holding the
// query address. i_cfg_data written with i_cfg_valid sets the user limit; o_cfg_ready is
// always high. The user must make writes only while no request is in flight; the block
// itself does not enforce it. Flow: every cell compares the request against its region
// in the compare state, then an OR tree of L = ceil(log4(MAX_REGIONS)) registered levels
// gathers the answer and the result register is written in the done state. The next
// request is accepted the cycle after the result is written, so only one request is in
// work at a time. A result waiting on a stalled receiver does not block the next
// request; only its final write waits for the result register to drain.
// Reset empties the table, sets the user limit to 2^47 and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module sorted_region_table #(
    parameter int MAX_REGIONS = 64,
    parameter int PAGE_SHIFT  = 12
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  srt_pkg::t_req              i_in,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output srt_pkg::t_rsp              o_out,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire  [srt_pkg::ADDR_W-1:0] i_cfg_data
);
    import srt_pkg::*;

    localparam int SP_W   = ADDR_W - PAGE_SHIFT;
    localparam int EP_W   = SP_W + 1;
    localparam int DATA_W = SP_W + EP_W + FLAGS_W;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int LEVELS = ($clog2(MAX_REGIONS) + 1) / 2;
    localparam int WAIT_W = $clog2(LEVELS + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_REGIONS);
    localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(LEVELS - 1);
    localparam logic [ADDR_W:0]   PAGE_MASK = (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [WAIT_W-1:0]  r_wait, n_wait;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_limit;
    logic               r_cmd;
    logic               r_bad;
    logic [SP_W-1:0]    r_sp;
    logic [EP_W-1:0]    r_ep;
    logic [SP_W-1:0]    r_qp;
    logic [FLAGS_W-1:0] r_flags;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    logic               w_accept;
    logic               w_fire;
    logic               w_do_ins;
    logic [ADDR_W:0]    w_end_up;
    t_cell_ctl          w_ctl;
    logic [DATA_W:0]    w_root;
    logic [SP_W-1:0]    w_hit_sp;
    logic [EP_W-1:0]    w_hit_ep;
    logic [FLAGS_W-1:0] w_hit_fl;

    logic               w_le   [MAX_REGIONS];
    logic [DATA_W-1:0]  w_cell [MAX_REGIONS];
    logic [DATA_W:0]    w_leaf [MAX_REGIONS];

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_fire   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_do_ins = w_fire && !r_bad && (r_cmd == CMD_INSERT) && !w_root[DATA_W]
                      && (r_count != CNT_FULL);
    assign w_end_up = {1'b0, i_in.end_addr} + PAGE_MASK;

    assign w_ctl.cmp  = (r_state == S_CMP);
    assign w_ctl.find = (r_cmd == CMD_FIND);
    assign w_ctl.ins  = w_do_ins;

    assign {w_hit_sp, w_hit_ep, w_hit_fl} = w_root[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_in.cmd;
            r_bad   <= (i_in.end_addr <= i_in.start_addr) || (i_in.end_addr > r_limit);
            r_sp    <= i_in.start_addr[ADDR_W-1:PAGE_SHIFT];
            r_ep    <= w_end_up[ADDR_W:PAGE_SHIFT];
            r_qp    <= i_in.query_addr[ADDR_W-1:PAGE_SHIFT];
            r_flags <= i_in.region_flags_in;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_WAIT;
                n_wait  = WAIT_LAST;
            end
            S_WAIT: begin
                if (r_wait == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            S_DONE: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = w_do_ins ? r_count + 1'b1 : r_count;
        n_out   = '0;
        n_out.entry_count = ENTRY_W'(n_count);
        if (r_bad && (r_cmd == CMD_INSERT)) begin
            n_out.status = ST_BAD_RANGE;
        end else if (r_cmd == CMD_FIND) begin
            if (w_root[DATA_W]) begin
                n_out.status    = ST_FOUND;
                n_out.hit_start = {w_hit_sp, {PAGE_SHIFT{1'b0}}};
                n_out.hit_end   = ADDR_W'({w_hit_ep, {PAGE_SHIFT{1'b0}}});
                n_out.hit_flags = w_hit_fl;
            end else begin
                n_out.status = ST_NOT_FOUND;
            end
        end else if (w_root[DATA_W]) begin
            n_out.status = ST_OVERLAP;
        end else if (r_count == CNT_FULL) begin
            n_out.status = ST_FULL;
        end else begin
            n_out.status    = ST_INSERTED;
            n_out.hit_start = {r_sp, {PAGE_SHIFT{1'b0}}};
            n_out.hit_end   = ADDR_W'({r_ep, {PAGE_SHIFT{1'b0}}});
            n_out.hit_flags = r_flags;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        logic              w_left_le;
        logic [DATA_W-1:0] w_left;
        if (i == 0) begin : g_head
            assign w_left_le = 1'b1;
            assign w_left    = '0;
        end else begin : g_body
            assign w_left_le = w_le[i-1];
            assign w_left    = w_cell[i-1];
        end
        srt_cell #(
            .IDX   (i),
            .CNT_W (CNT_W),
            .SP_W  (SP_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_count   (r_count),
            .i_sp      (r_sp),
            .i_ep      (r_ep),
            .i_qp      (r_qp),
            .i_flags   (r_flags),
            .i_left_le (w_left_le),
            .i_left    (w_left),
            .o_le      (w_le[i]),
            .o_cell    (w_cell[i]),
            .o_leaf    (w_leaf[i])
        );
    end

    srt_or_tree #(
        .N      (MAX_REGIONS),
        .W      (DATA_W + 1),
        .LEVELS (LEVELS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== design/srt_cell.sv =====
// One slot of the sorted region table: stored region, local compares and shift logic.
// Depends on srt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int SP_W  = 36
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  srt_pkg::t_cell_ctl         i_ctl,
    input  wire  [CNT_W-1:0]           i_count,
    input  wire  [SP_W-1:0]            i_sp,
    input  wire  [SP_W:0]              i_ep,
    input  wire  [SP_W-1:0]            i_qp,
    input  wire  [srt_pkg::FLAGS_W-1:0] i_flags,
    input  wire                        i_left_le,
    input  wire  [2*SP_W+srt_pkg::FLAGS_W:0] i_left,
    output logic                       o_le,
    output logic [2*SP_W+srt_pkg::FLAGS_W:0] o_cell,
    output logic [2*SP_W+srt_pkg::FLAGS_W+1:0] o_leaf
);
    import srt_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [SP_W-1:0]    r_start;
    logic [SP_W:0]      r_end;
    logic [FLAGS_W-1:0] r_flags;
    logic               r_le;
    logic               r_match;
    logic               w_in_use;
    logic               w_hit;
    logic               w_over;

    assign w_in_use = MY_IDX < i_count;
    assign w_hit    = (r_start <= i_qp) && ({1'b0, i_qp} < r_end);
    assign w_over   = ({1'b0, i_sp} < r_end) && ({1'b0, r_start} < i_ep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le    <= 1'b0;
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_le    <= w_in_use && (r_start <= i_sp);
            r_match <= w_in_use && (i_ctl.find ? w_hit : w_over);
        end
    end

    // Entries above the insert point move up by one; the first of them takes the new region.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_le) begin
            if (i_left_le) begin
                r_start <= i_sp;
                r_end   <= i_ep;
                r_flags <= i_flags;
            end else begin
                {r_start, r_end, r_flags} <= i_left;
            end
        end
    end

    assign o_le   = r_le;
    assign o_cell = {r_start, r_end, r_flags};
    assign o_leaf = r_match ? {1'b1, r_start, r_end, r_flags} : '0;

endmodule

`default_nettype wire

// ===== design/srt_or_tree.sv =====
// Registered four-way OR tree that gathers the cell match flags and hit data.
// For a find at most one cell reports a hit, so the OR of masked leaves selects it; an insert uses only the match bit.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srt_or_tree #(
    parameter int N      = 64,
    parameter int W      = 82,
    parameter int LEVELS = 3
) (
    input  wire          i_clk,
    input  wire  [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);

    localparam int LEAVES = 1 << (2 * LEVELS);
    localparam int INNER  = (LEAVES - 1) / 3;

    logic [W-1:0] w_leaf [LEAVES];
    logic [W-1:0] r_node [INNER];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign w_leaf[i] = i_leaf[i];
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    // Node k has children 4k+1 .. 4k+4; indexes at or above INNER are leaves.
    for (genvar k = 0; k < INNER; k++) begin : g_node
        logic [W-1:0] w_child [4];
        for (genvar j = 0; j < 4; j++) begin : g_ch
            if (4 * k + 1 + j >= INNER) begin : g_from_leaf
                assign w_child[j] = w_leaf[4 * k + 1 + j - INNER];
            end else begin : g_from_node
                assign w_child[j] = r_node[4 * k + 1 + j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_node[k] <= w_child[0] | w_child[1] | w_child[2] | w_child[3];
        end
    end

    assign o_root = r_node[0];

endmodule

`default_nettype wire

// ===== design/srt_checker.sv =====
// Port level checks of the sorted region table, attached to it by a bind.
// Depends on srt_pkg and sorted_region_table.
`timescale 1ns / 1ps
`default_nettype none

module srt_checker #(
    parameter int MAX_REGIONS = 64
) (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        o_in_stall,
    input srt_pkg::t_req              i_in,
    input wire                        o_out_valid,
    input wire                        i_out_stall,
    input srt_pkg::t_rsp              o_out,
    input wire                        i_cfg_valid,
    input wire                        o_cfg_ready,
    input wire  [srt_pkg::ADDR_W-1:0] i_cfg_data
);
    import srt_pkg::*;

    localparam logic [ENTRY_W-1:0] FULL_COUNT = ENTRY_W'(MAX_REGIONS);

    // A held result stays put until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    // Only one request is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in work");

    // Failed or missed requests carry no region.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_INSERTED && o_out.status != ST_FOUND
        |-> o_out.hit_start == '0 && o_out.hit_end == '0 && o_out.hit_flags == '0)
        else $error("failed request reports region data");

    // A full table report only happens with every slot in use.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.entry_count == FULL_COUNT)
        else $error("table full reported with free slots");

endmodule

bind sorted_region_table srt_checker #(
    .MAX_REGIONS (MAX_REGIONS)
) u_srt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

// ===== dv/tb_sorted_region_table.sv =====
`timescale 1ns / 1ps
// Testbench of the sorted region table: directed and random insert and find requests,
// each result checked against a behavioral copy of the table held in this file.
// Depends on srt_pkg and sorted_region_table.

module tb_sorted_region_table;

    import srt_pkg::*;

    localparam int MAX_REGIONS   = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int SP_W          = ADDR_W - PAGE_SHIFT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 40;

    localparam logic [ADDR_W-1:0] ADDR_ONES  = '1;
    localparam logic [ADDR_W:0]   PAGE_BYTES = (ADDR_W + 1)'(1) << PAGE_SHIFT;
    localparam logic [ADDR_W:0]   PAGE_MASK  = PAGE_BYTES - 1;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_req              in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_rsp              out_rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data  = '0;

    // Expected table contents, stored as page numbers in ascending order.
    logic [SP_W-1:0]    tbl_start [MAX_REGIONS];
    logic [SP_W:0]      tbl_end   [MAX_REGIONS];
    logic [FLAGS_W-1:0] tbl_flags [MAX_REGIONS];
    int                 tbl_count  = 0;
    logic [ADDR_W-1:0]  user_limit = LIMIT_RESET;

    t_rsp region_rsp_q [$];
    int   error_count  = 0;
    int   cycle_count  = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic holdoff_req  = 1'b0;
    logic holdoff_seen = 1'b0;
    int   holdoff_left = 0;

    sorted_region_table #(
        .MAX_REGIONS(MAX_REGIONS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_rsp),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_region_table verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, or one long hold-off each time holdoff_req toggles.
    always @(posedge clk) begin
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Applies one request to the expected table and returns the result it must give.
    function automatic t_rsp model_region_cmd(input t_req r);
        t_rsp            rsp;
        logic [ADDR_W:0] lo, hi, q;
        logic [SP_W-1:0] sp;
        logic [SP_W:0]   ep;
        int              i, j, pos;
        bit              done, clash;
        rsp   = '0;
        pos   = 0;
        done  = 1'b0;
        clash = 1'b0;
        q     = {1'b0, r.query_addr};
        if (r.cmd == CMD_FIND) begin
            rsp.status = ST_NOT_FOUND;
            for (i = 0; i < tbl_count && !done; i++) begin
                lo = {1'b0, tbl_start[i], {PAGE_SHIFT{1'b0}}};
                hi = {tbl_end[i], {PAGE_SHIFT{1'b0}}};
                if (q < lo) begin
                    done = 1'b1;
                end else if (q < hi) begin
                    rsp.status    = ST_FOUND;
                    rsp.hit_start = lo[ADDR_W-1:0];
                    rsp.hit_end   = hi[ADDR_W-1:0];
                    rsp.hit_flags = tbl_flags[i];
                    done          = 1'b1;
                end
            end
        end else if (r.end_addr <= r.start_addr || r.end_addr > user_limit) begin
            rsp.status = ST_BAD_RANGE;
        end else begin
            sp = r.start_addr[ADDR_W-1:PAGE_SHIFT];
            hi = ({1'b0, r.end_addr} + PAGE_MASK) >> PAGE_SHIFT;
            ep = hi[SP_W:0];
            for (i = 0; i < tbl_count && !done; i++) begin
                if ({1'b0, sp} < tbl_end[i] && tbl_start[i] < ep) begin
                    clash = 1'b1;
                    done  = 1'b1;
                end else if (tbl_start[i] > sp) begin
                    done = 1'b1;
                end else begin
                    pos = i + 1;
                end
            end
            if (clash) begin
                rsp.status = ST_OVERLAP;
            end else if (tbl_count >= MAX_REGIONS) begin
                rsp.status = ST_FULL;
            end else begin
                for (j = tbl_count; j > pos; j--) begin
                    tbl_start[j] = tbl_start[j-1];
                    tbl_end[j]   = tbl_end[j-1];
                    tbl_flags[j] = tbl_flags[j-1];
                end
                tbl_start[pos] = sp;
                tbl_end[pos]   = ep;
                tbl_flags[pos] = r.region_flags_in;
                tbl_count++;
                lo = {1'b0, sp, {PAGE_SHIFT{1'b0}}};
                hi = {ep, {PAGE_SHIFT{1'b0}}};
                rsp.status    = ST_INSERTED;
                rsp.hit_start = lo[ADDR_W-1:0];
                // A region ending at the top of the address space reads back as zero.
                rsp.hit_end   = hi[ADDR_W-1:0];
                rsp.hit_flags = r.region_flags_in;
            end
        end
        rsp.entry_count = ENTRY_W'(tbl_count);
        return rsp;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] u;
        u = {$urandom, $urandom};
        return u[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] rand_below(input logic [ADDR_W-1:0] bound);
        logic [63:0] u;
        u = {$urandom, $urandom};
        return (bound == 0) ? '0 : ADDR_W'(u % bound);
    endfunction

    function automatic t_req make_insert(input logic [ADDR_W-1:0] lo, hi,
                                         input logic [FLAGS_W-1:0] fl);
        t_req r;
        r.cmd             = CMD_INSERT;
        r.start_addr      = lo;
        r.end_addr        = hi;
        r.region_flags_in = fl;
        r.query_addr      = rand_addr();
        return r;
    endfunction

    function automatic t_req make_find(input logic [ADDR_W-1:0] q);
        t_req r;
        r.cmd             = CMD_FIND;
        r.start_addr      = rand_addr();
        r.end_addr        = rand_addr();
        r.region_flags_in = FLAGS_W'($urandom);
        r.query_addr      = q;
        return r;
    endfunction

    // Random request, mostly at stored regions: hits, edges, overlaps and neighbors.
    function automatic t_req random_cmd();
        t_req            r;
        logic [ADDR_W:0] lo, hi, span, a;
        logic [63:0]     u;
        int              i, k;
        r.cmd             = 1'($urandom_range(1));
        r.start_addr      = rand_addr();
        r.end_addr        = rand_addr();
        r.region_flags_in = FLAGS_W'($urandom);
        r.query_addr      = rand_addr();
        lo   = '0;
        hi   = PAGE_BYTES;
        if (tbl_count > 0) begin
            i  = $urandom_range(tbl_count - 1);
            lo = {1'b0, tbl_start[i], {PAGE_SHIFT{1'b0}}};
            hi = {tbl_end[i], {PAGE_SHIFT{1'b0}}};
        end
        span = hi - lo;
        u    = {$urandom, $urandom};
        k    = $urandom_range(99);
        if (r.cmd == CMD_FIND) begin
            if (tbl_count > 0 && k < 45) begin
                a            = lo + (ADDR_W + 1)'(u % span);
                r.query_addr = a[ADDR_W-1:0];
            end else if (tbl_count > 0 && k < 70) begin
                case ($urandom_range(3))
                    0:       a = lo;
                    1:       a = hi - 1;
                    2:       a = hi;
                    default: a = lo - 1;
                endcase
                r.query_addr = a[ADDR_W-1:0];
            end
        end else if (k < 15) begin
            a = {1'b0, user_limit} + 1 + (ADDR_W + 1)'(u % 65536);
            if ($urandom_range(1) || a > ADDR_ONES) begin
                a          = {1'b0, r.start_addr};
                r.end_addr = (u[11:0] <= a) ? ADDR_W'(a - u[11:0]) : '0;
            end else begin
                r.end_addr   = a[ADDR_W-1:0];
                r.start_addr = ADDR_W'(a - 1 - (u % a));
            end
        end else if (tbl_count > 0 && k < 70) begin
            // Starts inside or a little below a stored region.
            a            = lo + (ADDR_W + 1)'(u % span);
            a            = (a > u[44:32]) ? a - u[44:32] : '0;
            r.start_addr = a[ADDR_W-1:0];
            a            = a + 1 + ($urandom % (span + 4096));
            r.end_addr   = (a > ADDR_ONES) ? ADDR_ONES : a[ADDR_W-1:0];
        end else if (tbl_count > 0 && k < 80) begin
            // Touches a stored region from above or below.
            if ($urandom_range(1) && hi <= ADDR_ONES) begin
                r.start_addr = hi[ADDR_W-1:0];
                a            = hi + 1 + u[13:0];
                r.end_addr   = (a > ADDR_ONES) ? ADDR_ONES : a[ADDR_W-1:0];
            end else begin
                r.end_addr   = lo[ADDR_W-1:0];
                a            = (lo > u[13:0]) ? lo - 1 - u[13:0] : '0;
                r.start_addr = a[ADDR_W-1:0];
            end
        end else begin
            a            = {1'b0, rand_below(user_limit)};
            r.start_addr = a[ADDR_W-1:0];
            a            = a + 1 + ($urandom & ((32'd1 << $urandom_range(24)) - 1));
            r.end_addr   = (a > ADDR_ONES) ? ADDR_ONES : a[ADDR_W-1:0];
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic issue_cmd(input t_req r);
        int gap;
        bit taken;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        region_rsp_q.push_back(model_region_cmd(r));
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (region_rsp_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_user_limit(input logic [ADDR_W-1:0] value);
        bit taken;
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = (cfg_ready === 1'b1);
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        user_limit = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        idle_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    function automatic bit field_ok(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
        if (want === got) return 1'b1;
        if (error_count < REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        return 1'b0;
    endfunction

    always @(negedge clk) begin : check_results
        t_rsp want;
        bit   ok;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (region_rsp_q.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("%0t ns: result with no request outstanding, expected none, actual %0h",
                             $time, out_rsp);
                error_count++;
            end else begin
                want = region_rsp_q.pop_front();
                ok = field_ok("status", 64'(want.status), 64'(out_rsp.status))
                   & field_ok("hit_start", 64'(want.hit_start), 64'(out_rsp.hit_start))
                   & field_ok("hit_end", 64'(want.hit_end), 64'(out_rsp.hit_end))
                   & field_ok("hit_flags", 64'(want.hit_flags), 64'(out_rsp.hit_flags))
                   & field_ok("entry_count", 64'(want.entry_count),
                              64'(out_rsp.entry_count));
                if (!ok) error_count++;
            end
        end
    end

    task automatic test_empty_table();
        issue_cmd(make_find('0));
        issue_cmd(make_find(ADDR_ONES));
        issue_cmd(make_find(rand_addr()));
        wait_quiet();
    endtask

    task automatic test_insert_find_basics();
        issue_cmd(make_insert(48'h1000, 48'h3000, 8'hA5));
        issue_cmd(make_insert(48'h5123, 48'h6001, 8'h00));
        issue_cmd(make_insert(48'h2FFF, 48'h4000, 8'h11));
        // Touches both neighbors without overlapping; lands between them.
        issue_cmd(make_insert(48'h3000, 48'h5000, 8'hFF));
        issue_cmd(make_find(48'h2FFF));
        issue_cmd(make_find(48'h3000));
        issue_cmd(make_find(48'h6FFF));
        issue_cmd(make_find(48'h7000));
        issue_cmd(make_find(48'h0FFF));
        issue_cmd(make_insert(48'h8000, 48'h8000, 8'h01));
        issue_cmd(make_insert(48'h9000, 48'h8000, 8'h02));
        issue_cmd(make_insert(LIMIT_RESET - 48'h1000, LIMIT_RESET + 48'h1, 8'h03));
        issue_cmd(make_insert(LIMIT_RESET - 48'h1000, LIMIT_RESET, 8'h5A));
        issue_cmd(make_find(LIMIT_RESET - 48'h1));
        wait_quiet();
    endtask

    task automatic test_address_top();
        write_user_limit(ADDR_ONES);
        // The rounded end is 2^48 and reads back as zero.
        issue_cmd(make_insert(ADDR_ONES - 48'h7FF, ADDR_ONES, 8'hC3));
        issue_cmd(make_find(ADDR_ONES));
        issue_cmd(make_insert('0, ADDR_ONES, 8'h3C));
        write_user_limit('0);
        issue_cmd(make_insert('0, 48'h1, 8'h77));
        issue_cmd(make_insert('0, '0, 8'h88));
        issue_cmd(make_find(48'h1000));
        wait_quiet();
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) issue_cmd(random_cmd());
        wait_quiet();
    endtask

    task automatic test_output_holdoff();
        set_idling(0, 0);
        holdoff_req <= ~holdoff_req;
        repeat (40) issue_cmd(random_cmd());
        wait_quiet();
    endtask

    task automatic test_fill_to_capacity();
        logic [ADDR_W:0] lo, gap_lo;
        int              tries, i;
        bit              have_gap;
        set_idling(0, 0);
        tries = 0;
        while (tbl_count < MAX_REGIONS && tries < 400) begin
            lo = {1'b0, rand_below(user_limit)};
            issue_cmd(make_insert(lo[ADDR_W-1:0], ADDR_W'(lo + 1 + $urandom_range(65535)),
                                  FLAGS_W'($urandom)));
            tries++;
        end
        // A free page between two stored regions: only the full check can reject it.
        have_gap = 1'b0;
        gap_lo   = '0;
        for (i = 0; i + 1 < tbl_count && !have_gap; i++) begin
            if (tbl_end[i] < tbl_start[i+1]) begin
                gap_lo   = {tbl_end[i], {PAGE_SHIFT{1'b0}}};
                have_gap = (gap_lo < user_limit);
            end
        end
        if (have_gap)
            issue_cmd(make_insert(gap_lo[ADDR_W-1:0], ADDR_W'(gap_lo + 1),
                                  FLAGS_W'($urandom)));
        // Overlap is reported ahead of a full table.
        lo = {1'b0, tbl_start[0], {PAGE_SHIFT{1'b0}}};
        issue_cmd(make_insert(lo[ADDR_W-1:0], ADDR_W'(lo + 1), FLAGS_W'($urandom)));
        issue_cmd(make_find(lo[ADDR_W-1:0]));
        wait_quiet();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_insert_find_basics();
        test_address_top();

        write_user_limit(LIMIT_RESET);
        set_idling(0, 0);
        test_random_traffic(250);
        set_idling(79, 0);
        test_random_traffic(180);
        write_user_limit(48'h0100_0000_0000);
        set_idling(0, 79);
        test_random_traffic(180);
        write_user_limit(LIMIT_RESET);
        set_idling(29, 29);
        test_random_traffic(180);
        test_output_holdoff();
        test_fill_to_capacity();
        set_idling(29, 29);
        test_random_traffic(150);
        write_user_limit('0);
        set_idling(0, 0);
        test_random_traffic(30);

        wait_quiet();
        if (error_count == 0 && region_rsp_q.size() == 0) begin
            $display("sorted_region_table verification clean");
        end else begin
            $display("sorted_region_table verification failed");
        end
        $finish;
    end

endmodule
